// File: sv/tcww_pkg.sv
// tcww_pkg: shared constants and types for the word-wrap console writer
// no dependencies
package tcww_pkg;

	localparam int TEXT_CELLS = 16384;
	localparam int MAX_WIDTH  = 128;
	localparam int ADDR_W     = $clog2(TEXT_CELLS);
	localparam int WCNT_W     = $clog2(MAX_WIDTH) + 1;
	localparam int WIDX_W     = $clog2(MAX_WIDTH);
	localparam int LINE_W     = 14;
	localparam int COL_W      = 7;
	localparam int TL_W       = 15;
	localparam logic [TL_W-1:0] RING_LIMIT = 15'd16384;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_TALK  = 8'd1;
	localparam logic [7:0] CH_COL   = 8'd2;

	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_LINES = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PUSH_RD,
		ST_PUSH_WAIT,
		ST_PUSH_PLACE,
		ST_DISPATCH,
		ST_FLUSH_RD,
		ST_FLUSH_WAIT,
		ST_FLUSH_PLACE,
		ST_SINGLE,
		ST_BLANK,
		ST_LAST,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

	// text store write request
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [8:0]        data;
	} store_req_t;

endpackage

// File: sv/tcww_store.sv
// tcww_store: text cell memory, one port, registered read data
// depends on tcww_pkg
module tcww_store (
	input  logic                       clk,
	input  tcww_pkg::store_req_t       req,
	input  logic                       re,
	output logic [8:0]                 rdata
);
	import tcww_pkg::*;

	logic [8:0] mem [TEXT_CELLS];

	// single port, write has priority
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.data;
		end else if (re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

// File: sv/tcww_wordbuf.sv
// tcww_wordbuf: pending-word character memory used as a circular buffer
// depends on tcww_pkg
module tcww_wordbuf (
	input  logic                       clk,
	input  logic                       we,
	input  logic [tcww_pkg::WIDX_W-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic [tcww_pkg::WIDX_W-1:0] raddr,
	output logic [7:0]                 rdata
);
	import tcww_pkg::*;

	logic [7:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/text_console_word_wrap_writer.sv
// text_console_word_wrap_writer: top level, sequencer and cursor state
// depends on tcww_pkg, tcww_store, tcww_wordbuf
//
// Usage: one input word per item on the in channel (valid/ready). kind 0
// is a message byte, kind 1 reads one stored cell. Each item yields one
// result word on the out channel. Items are processed one at a time by a
// sequencer around a single-port text memory (one access per cycle) and a
// circular pending-word memory.
// A buffered word byte is written to the pending-word memory; a byte that
// ends a word flushes the pending characters one at a time and blanks the
// cells of every line begun (line width cells); a read waits for the
// registered cell.
// Reset: a clearing pass writes a space to all TEXT_CELLS cells, one per
// cycle, while in_ready stays low; configuration writes are still taken.
// After each configuration write in_ready stays low while the line index
// is reduced to the ring size.
// When the receiver stalls the result waits in the output register; the
// next item is still taken and worked, then holds at its end until the
// register frees.
// Registers: 0 line_width at byte 0, 1 total_lines at byte 4.
module text_console_word_wrap_writer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [7:0]                char_code,
	input  logic                      last_of_message,
	input  logic [13:0]               read_line,
	input  logic [6:0]                read_column,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [8:0]                cell_value,
	output logic [6:0]                cursor_column,
	output logic [13:0]               current_line,
	output logic                      talk_sound,
	output logic [1:0]                lines_started,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import tcww_pkg::*;

	logic [7:0]  line_width_q;
	logic [14:0] total_lines_q;
	state_t      state_q, state_d;

	// item latch
	logic              kind_q, last_q;
	logic [7:0]        char_q;
	logic [13:0]       rline_q;
	logic [6:0]        rcol_q;

	// cursor state
	logic [13:0]       line_q;
	logic [7:0]        col_q;
	logic              ret_q, colour_q, start_q, talk_q;
	logic [WCNT_W-1:0] wcnt_q;
	logic [WIDX_W-1:0] whead_q;
	logic [1:0]        begun_q;
	logic [ADDR_W:0]   clr_q;
	logic [7:0]        blank_q;
	logic [ADDR_W-1:0] base_q;
	logic [7:0]        pch_q;
	logic [7:0]        pcol_q;
	state_t            ret_st_q;

	// line index reduced to the ring size
	logic [13:0]       lmod_q;
	logic [3:0]        red_q;
	logic [28:0]       red_div;

	// effective configuration
	logic [7:0]  w_eff;
	logic [14:0] tl_eff;
	always_comb begin
		w_eff = line_width_q;
		if (w_eff == 8'd0) w_eff = 8'd1;
		if (w_eff > 8'(MAX_WIDTH)) w_eff = 8'(MAX_WIDTH);
		tl_eff = total_lines_q;
		if (tl_eff == 15'd0) tl_eff = 15'd1;
		if (tl_eff > RING_LIMIT) tl_eff = RING_LIMIT;
	end

	// apb
	assign pready = 1'b1;
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_WIDTH) prdata = {24'd0, line_width_q};
		else                       prdata = {17'd0, total_lines_q};
	end

	// ring size shifted for the current reduction step
	assign red_div = 29'(tl_eff) << (red_q - 4'd1);

	// memories
	store_req_t        sreq;
	logic              sre;
	logic [8:0]        srdata;
	logic              bwe;
	logic [WIDX_W-1:0] bwaddr, braddr;
	logic [7:0]        brdata;

	tcww_store u_store (.clk, .req(sreq), .re(sre), .rdata(srdata));
	tcww_wordbuf u_wbuf (.clk, .we(bwe), .waddr(bwaddr), .wdata(char_q),
		.raddr(braddr), .rdata(brdata));

	// place one character: wrap decision and line start
	logic [WCNT_W-1:0] look;
	logic [13:0] pl_line;
	logic [7:0]  pl_col;
	logic        pl_newline;
	logic [13:0] ln_red;
	always_comb begin
		ln_red  = lmod_q;
		pl_col  = col_q;
		if (9'(look) != 9'(w_eff) && 9'(col_q) + 9'(look) > 9'(w_eff)) pl_col = 8'd0;
		pl_line = ln_red;
		if (ret_q) pl_line = (pl_line == 14'd0) ? 14'(tl_eff - 15'd1) : pl_line - 14'd1;
		pl_newline = (pl_col == 8'd0);
		if (pl_newline)
			pl_line = (15'(pl_line) + 15'd1 >= tl_eff) ? 14'd0 : pl_line + 14'd1;
	end

	logic [WCNT_W-1:0] flush_rem;
	always_comb begin
		flush_rem = wcnt_q;
		if (9'(flush_rem) > 9'(w_eff)) flush_rem = WCNT_W'(w_eff);
	end

	logic is_word;
	assign is_word = (char_q > 8'd32) && (char_q < 8'd128);
	assign braddr  = whead_q;
	assign bwaddr  = WIDX_W'(whead_q + WIDX_W'(wcnt_q));
	assign bwe     = (state_q == ST_PUSH_RD) && !(wcnt_q >= WCNT_W'(w_eff));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == (ADDR_W+1)'(TEXT_CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (in_valid && in_ready) begin
				if (kind) state_d = ST_READ_WAIT;
				else if (start_q && (char_code == CH_TALK || char_code == CH_COL))
					state_d = last_of_message ? ST_LAST : ST_DONE;
				else if (char_code > 8'd32 && char_code < 8'd128) state_d = ST_PUSH_RD;
				else state_d = ST_DISPATCH;
			end
			ST_PUSH_RD: state_d = (wcnt_q >= WCNT_W'(w_eff)) ? ST_PUSH_WAIT
				: (last_q ? ST_LAST : ST_DONE);
			ST_PUSH_WAIT:  state_d = ST_PUSH_PLACE;
			ST_PUSH_PLACE: state_d = ST_BLANK;
			ST_DISPATCH: state_d = (wcnt_q != '0) ? ST_FLUSH_WAIT
				: ((char_q != 8'd0) ? ST_SINGLE : (last_q ? ST_LAST : ST_DONE));
			ST_FLUSH_RD:    state_d = ST_FLUSH_WAIT;
			ST_FLUSH_WAIT:  state_d = ST_FLUSH_PLACE;
			ST_FLUSH_PLACE: state_d = ST_BLANK;
			ST_SINGLE:      state_d = ST_BLANK;
			ST_BLANK: if (blank_q == '0) state_d = ret_st_q;
			ST_LAST: state_d = (wcnt_q != '0) ? ST_FLUSH_WAIT : ST_DONE;
			ST_READ_WAIT: state_d = ST_DONE;
			ST_DONE: if (!out_valid || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// store access and look-ahead selection
	logic [ADDR_W-1:0] cell_addr_line;
	logic [21:0] prod;
	assign prod = pl_line * 22'(w_eff);
	always_comb begin
		look = '0;
		if (state_q == ST_PUSH_PLACE) look = WCNT_W'(w_eff);
		else if (state_q == ST_FLUSH_PLACE) look = flush_rem;
		cell_addr_line = ADDR_W'(prod);
		sreq = '0;
		sre  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				sreq.we = 1'b1; sreq.addr = ADDR_W'(clr_q); sreq.data = {1'b0, CH_SPACE};
			end
			ST_BLANK: if (blank_q != '0) begin
				sreq.we = 1'b1;
				sreq.addr = ADDR_W'(base_q + ADDR_W'(blank_q - 8'd1));
				sreq.data = {1'b0, CH_SPACE};
			end else if (pch_q != CH_LF && pch_q != CH_CR) begin
				sreq.we = 1'b1;
				sreq.addr = ADDR_W'(base_q + ADDR_W'(pcol_q));
				sreq.data = {colour_q, pch_q};
			end
			default: begin
				sre = 1'b1;
				sreq.addr = ADDR_W'(rline_q * 22'(w_eff) + 22'(rcol_q));
			end
		endcase
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; clr_q <= '0;
			line_width_q <= 8'd38; total_lines_q <= 15'd431;
			line_q <= 14'd430; col_q <= '0; ret_q <= 1'b0; colour_q <= 1'b0;
			start_q <= 1'b1; wcnt_q <= '0; whead_q <= '0; out_valid <= 1'b0;
			begun_q <= '0; talk_q <= 1'b0; blank_q <= '0; ret_st_q <= ST_DONE;
			base_q <= '0; pch_q <= '0; pcol_q <= '0;
			lmod_q <= 14'd430; red_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && paddr[2] == REG_WIDTH) line_width_q <= pwdata[7:0];
			if (cfg_wr && paddr[2] == REG_LINES) total_lines_q <= pwdata[14:0];
			if (out_valid && out_ready && state_q != ST_DONE) out_valid <= 1'b0;

			// reduce the line index after a register change, else follow placements
			if (cfg_wr) begin
				lmod_q <= line_q; red_q <= 4'd15;
			end else if (red_q != 4'd0) begin
				if (29'(lmod_q) >= red_div) lmod_q <= 14'(29'(lmod_q) - red_div);
				red_q <= red_q - 4'd1;
			end else if (state_q == ST_PUSH_PLACE || state_q == ST_FLUSH_PLACE
				|| state_q == ST_SINGLE) begin
				lmod_q <= pl_line;
			end

			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: if (in_valid && in_ready) begin
					kind_q <= kind; char_q <= char_code; last_q <= last_of_message;
					rline_q <= read_line; rcol_q <= read_column;
					begun_q <= '0; talk_q <= 1'b0;
					if (!kind && start_q) begin
						start_q <= 1'b0;
						colour_q <= (char_code == CH_TALK || char_code == CH_COL);
						talk_q <= (char_code == CH_TALK);
					end
				end
				ST_PUSH_RD: begin
					ret_st_q <= ST_PUSH_RD;
					if (!(wcnt_q >= WCNT_W'(w_eff))) wcnt_q <= wcnt_q + 1'b1;
				end
				ST_PUSH_PLACE, ST_FLUSH_PLACE, ST_SINGLE: begin
					pch_q <= (state_q == ST_SINGLE) ? char_q : brdata;
					if (state_q != ST_SINGLE) begin
						whead_q <= whead_q + 1'b1; wcnt_q <= wcnt_q - 1'b1;
					end
					// a flush ahead of a separator goes on to place it; a flush at
					// the end of a message follows a word byte and just finishes
					ret_st_q <= (state_q == ST_PUSH_PLACE) ? ST_PUSH_RD
						: (state_q == ST_SINGLE) ? (last_q ? ST_LAST : ST_DONE)
						: (wcnt_q != WCNT_W'(1)) ? ST_FLUSH_RD
						: (!is_word && char_q != 8'd0) ? ST_SINGLE
						: ((!is_word && last_q) ? ST_LAST : ST_DONE);
					line_q <= pl_line;
					ret_q  <= 1'b0;
					base_q <= cell_addr_line;
					pcol_q <= pl_col;
					blank_q <= pl_newline ? w_eff : 8'd0;
					if (pl_newline && begun_q != 2'd3) begun_q <= begun_q + 1'b1;
					if ((state_q == ST_SINGLE ? char_q : brdata) == CH_LF) col_q <= '0;
					else if ((state_q == ST_SINGLE ? char_q : brdata) == CH_CR) begin
						col_q <= '0; ret_q <= 1'b1;
					end else col_q <= (pl_col + 8'd1 >= w_eff) ? 8'd0 : pl_col + 8'd1;
				end
				ST_DISPATCH: ret_st_q <= ST_DISPATCH;
				ST_LAST: begin
					ret_st_q <= ST_LAST; start_q <= 1'b1;
				end
				ST_BLANK: if (blank_q != '0) blank_q <= blank_q - 8'd1;
				ST_DONE: if (!out_valid || out_ready) begin
					out_valid <= 1'b1;
					cell_value <= kind_q ? srdata : 9'd0;
					cursor_column <= col_q[6:0];
					current_line <= line_q;
					talk_sound <= talk_q;
					lines_started <= begun_q;
				end
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE) && (red_q == 4'd0);

	// assertions
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready) else $error("accept during clear");
	a_wcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		9'(wcnt_q) <= 9'(MAX_WIDTH)) else $error("word count overflow");
	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && (!out_valid || out_ready) |=> out_valid)
		else $error("result lost");

endmodule

// File: verif/tcww_checker.sv
// tcww_checker: watches the channels and config port of the word-wrap writer,
// predicts every result word and compares; depends on tcww_pkg
`timescale 1ns / 100ps

module tcww_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  char_code,
	input  logic        last_of_message,
	input  logic [13:0] read_line,
	input  logic [6:0]  read_column,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [8:0]  cell_value,
	input  logic [6:0]  cursor_column,
	input  logic [13:0] current_line,
	input  logic        talk_sound,
	input  logic [1:0]  lines_started,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);
	import tcww_pkg::*;

	typedef struct {
		logic [8:0]  cval;
		logic [6:0]  col;
		logic [13:0] line;
		logic        talk;
		logic [1:0]  started;
	} result_t;

	localparam logic [2:0] ADDR_WIDTH = {REG_WIDTH, 2'b00};
	localparam logic [2:0] ADDR_LINES = {REG_LINES, 2'b00};

	// shadow copy of the writer
	logic [7:0]       width_reg;
	logic [TL_W-1:0]  lines_reg;
	logic [8:0]       cells [TEXT_CELLS];
	logic [7:0]       word_q [MAX_WIDTH];
	int unsigned      word_len;
	int unsigned      cur_line;
	int unsigned      cur_col;
	bit               cr_seen;
	bit               colour;
	bit               msg_start;
	int unsigned      new_lines;
	result_t          expected_q [$];

	function automatic int unsigned width_now();
		int unsigned w;
		w = width_reg;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned ring_now();
		int unsigned t;
		t = lines_reg;
		if (t == 0) t = 1;
		if (t > RING_LIMIT) t = RING_LIMIT;
		return t;
	endfunction

	function automatic int unsigned cell_ix(int unsigned ln, int unsigned cl);
		return (ln * width_now() + cl) % TEXT_CELLS;
	endfunction

	// write one byte at the cursor with its look-ahead length
	function automatic void put_char(int unsigned c, int unsigned look);
		int unsigned w;
		int unsigned tl;
		w  = width_now();
		tl = ring_now();
		if (cur_line >= tl) cur_line = cur_line % tl;
		if (look != w && cur_col + look > w) cur_col = 0;
		if (cr_seen) begin
			cur_line = (cur_line == 0) ? tl - 1 : cur_line - 1;
			cr_seen  = 0;
		end
		if (cur_col == 0) begin
			cur_line = (cur_line + 1 >= tl) ? 0 : cur_line + 1;
			for (int i = 0; i < w; i++)
				cells[cell_ix(cur_line, i)] = 9'(CH_SPACE);
			new_lines++;
		end
		if (c == CH_LF) begin
			cur_col = 0;
		end else if (c == CH_CR) begin
			cur_col = 0;
			cr_seen = 1;
		end else begin
			cells[cell_ix(cur_line, cur_col)] = {colour, 8'(c)};
			cur_col++;
			if (cur_col >= w) cur_col = 0;
		end
	endfunction

	function automatic void flush_pending();
		int unsigned w;
		int unsigned rem;
		w = width_now();
		for (int unsigned k = 0; k < word_len && k < MAX_WIDTH; k++) begin
			rem = word_len - k;
			if (rem > w) rem = w;
			put_char(word_q[k], rem);
		end
		word_len = 0;
	endfunction

	function automatic void add_to_word(int unsigned c);
		int unsigned w;
		w = width_now();
		while (word_len >= w && word_len > 0) begin
			put_char(word_q[0], w);
			for (int i = 1; i < word_len; i++) word_q[i-1] = word_q[i];
			word_len--;
		end
		word_q[word_len] = 8'(c);
		word_len++;
	endfunction

	function automatic result_t predict(logic k, logic [7:0] c, logic lst,
		logic [13:0] rl, logic [6:0] rc);
		result_t r;
		bit      taken;
		r.cval = '0;
		r.talk = 0;
		taken  = 0;
		new_lines = 0;
		if (k) begin
			r.cval = cells[cell_ix(rl, rc)];
		end else begin
			if (msg_start) begin
				msg_start = 0;
				if (c == CH_TALK || c == CH_COL) begin
					colour = 1;
					r.talk = (c == CH_TALK);
					taken  = 1;
				end else begin
					colour = 0;
				end
			end
			if (!taken) begin
				if (c > 32 && c < 128) begin
					add_to_word(c);
				end else begin
					flush_pending();
					if (c != 0) put_char(c, 0);
				end
			end
			if (lst) begin
				flush_pending();
				msg_start = 1;
			end
		end
		r.col     = 7'(cur_col);
		r.line    = 14'(cur_line);
		r.started = (new_lines > 3) ? 2'd3 : 2'(new_lines);
		return r;
	endfunction

	// predict on accepted input words, compare on accepted result words
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			width_reg  = 8'd38;
			lines_reg  = 15'd431;
			for (int i = 0; i < TEXT_CELLS; i++) cells[i] = 9'(CH_SPACE);
			word_len   = 0;
			cur_line   = 430;
			cur_col    = 0;
			cr_seen    = 0;
			colour     = 0;
			msg_start  = 1;
			fail_count = 0;
			expected_q.delete();
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_WIDTH) width_reg = pwdata[7:0];
				else if (paddr == ADDR_LINES) lines_reg = pwdata[TL_W-1:0];
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word at %0t", $realtime);
				end else begin
					want = expected_q.pop_front();
					if (want.cval !== cell_value || want.col !== cursor_column ||
						want.line !== current_line || want.talk !== talk_sound ||
						want.started !== lines_started) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch at %0t: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
								$realtime, want.cval, want.col, want.line, want.talk,
								want.started, cell_value, cursor_column, current_line,
								talk_sound, lines_started);
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(predict(kind, char_code, last_of_message,
					read_line, read_column));
			pending = expected_q.size();
		end
	end

endmodule

// File: verif/testbench.sv
// testbench: drives stimulus and config writes into the word-wrap writer and
// gives the verdict; depends on tcww_pkg, tcww_checker and the block itself
`timescale 1ns / 100ps

module testbench;
	import tcww_pkg::*;

	localparam logic [2:0] ADDR_WIDTH = {REG_WIDTH, 2'b00};
	localparam logic [2:0] ADDR_LINES = {REG_LINES, 2'b00};
	localparam int STALL_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 1000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        kind = 0;
	logic [7:0]  char_code = 8'd32;
	logic        last_of_message = 0;
	logic [13:0] read_line = '0;
	logic [6:0]  read_column = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [8:0]  cell_value;
	logic [6:0]  cursor_column;
	logic [13:0] current_line;
	logic        talk_sound;
	logic [1:0]  lines_started;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	bit calm = 0;
	bit hold_req = 0;
	int burst_left = 0;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	text_console_word_wrap_writer uut (.*);

	tcww_checker chk (.*);

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		bit held;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				out_ready = 0;
				held = 1;
				repeat (400) @(negedge clk);
			end else begin
				out_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
			end
		end
	end

	task automatic reg_write(logic [2:0] a, logic [31:0] d);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1; paddr = a; pwdata = d;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	task automatic send(logic k, logic [7:0] c, logic lst, logic [13:0] rl,
		logic [6:0] rc);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 30) begin
			in_valid = 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid = 1; kind = k; char_code = c; last_of_message = lst;
		read_line = rl; read_column = rc;
		do @(posedge clk); while (!in_ready);
	endtask

	// one random item: mostly word text, some separators, reads and noise
	task automatic random_item();
		int r;
		logic [7:0] c;
		logic lst;
		lst = ($urandom_range(0, 99) < 6);
		if (burst_left > 0) begin
			burst_left--;
			send(0, 8'($urandom_range(33, 127)), 0, 14'($urandom), 7'($urandom));
		end else if ($urandom_range(0, 99) < 15) begin
			send(1, 8'($urandom), 1'($urandom_range(0, 1)), 14'($urandom), 7'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) c = 8'($urandom_range(33, 127));
			else if (r < 70) c = CH_SPACE;
			else if (r < 76) c = CH_LF;
			else if (r < 80) c = CH_CR;
			else if (r < 86) c = 8'($urandom_range(128, 255));
			else if (r < 88) c = 8'd0;
			else if (r < 92) c = ($urandom_range(0, 1) != 0) ? CH_TALK : CH_COL;
			else if (r < 93) begin
				c = 8'($urandom_range(33, 127));
				burst_left = $urandom_range(120, 140);
			end else c = 8'($urandom_range(1, 255));
			send(0, c, lst, 14'($urandom), 7'($urandom));
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int widths [8];
		int rings [8];
		widths = '{38, 1, 0, 128, 200, 8, 16, 3};
		rings  = '{431, 1, 0, 16384, 30000, 5, 3, 2};

		repeat (12) @(negedge clk);
		arst_n = 1;

		reg_write(ADDR_WIDTH, 32'd38);
		reg_write(ADDR_LINES, 32'd431);

		// directed: colour bytes, separators, high and zero bytes, reads
		send(0, CH_TALK, 0, '0, '0);
		send(0, "a", 0, '0, '0);
		send(0, "b", 0, '0, '0);
		send(0, CH_SPACE, 0, '0, '0);
		send(0, CH_CR, 0, '0, '0);
		send(0, CH_LF, 0, '0, '0);
		send(0, "z", 1, '0, '0);
		send(0, CH_COL, 0, '0, '0);
		send(0, 8'd200, 0, '0, '0);
		send(0, 8'd0, 0, '0, '0);
		send(0, 8'd255, 0, '0, '0);
		send(0, CH_TALK, 0, '0, '0);
		send(0, 8'd127, 1, '0, '0);
		send(0, 8'd33, 1, '0, '0);
		send(1, 8'd0, 0, 14'd16383, 7'd127);
		send(1, 8'd255, 1, 14'd0, 7'd0);
		send(1, 8'd0, 0, 14'd431, 7'd1);

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			reg_write(ADDR_WIDTH, 32'(widths[ph]));
			reg_write(ADDR_LINES, 32'(rings[ph]));
			calm = (ph == 5);
			hold_req = (ph == 2);
			for (int n = 0; n < 88; n++) random_item();
		end

		wait_idle();
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
sv/tcww_pkg.sv
sv/tcww_store.sv
sv/tcww_wordbuf.sv
sv/text_console_word_wrap_writer.sv
verif/tcww_checker.sv
verif/testbench.sv
